@@ design/instruction_word_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// Instruction word decoder assertion macros
// Shared concurrent assertion forms for the decoder checks.
// ----------------------------------------------------------------------------
`ifndef INSTRUCTION_WORD_DECODER_DEFINES_SVH
`define INSTRUCTION_WORD_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define IWD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("instruction word decoder check failed");

// Next-cycle implication, disabled while reset is held
`define IWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("instruction word decoder check failed");

`endif

@@ design/iwd_pkg.sv @@
// ----------------------------------------------------------------------------
// Instruction word decoder package
// Opcode, funct and branch condition codes, kind numbers and the decode table.
// ----------------------------------------------------------------------------
package iwd_pkg;

  // Primary opcode, bits 31..26
  typedef enum logic [5:0] {
    OP_SPECIAL = 6'h00, OP_REGIMM = 6'h01, OP_J     = 6'h02, OP_JAL   = 6'h03,
    OP_BEQ     = 6'h04, OP_BNE    = 6'h05, OP_BLEZ  = 6'h06, OP_BGTZ  = 6'h07,
    OP_ADDI    = 6'h08, OP_ADDIU  = 6'h09, OP_SLTI  = 6'h0A, OP_SLTIU = 6'h0B,
    OP_ANDI    = 6'h0C, OP_ORI    = 6'h0D, OP_XORI  = 6'h0E, OP_LUI   = 6'h0F,
    OP_LB      = 6'h20, OP_LH     = 6'h21, OP_LWL   = 6'h22, OP_LW    = 6'h23,
    OP_LBU     = 6'h24, OP_LHU    = 6'h25, OP_SB    = 6'h28, OP_SH    = 6'h29,
    OP_SW      = 6'h2B
  } opcode_t;

  // Register-format function code, bits 5..0
  typedef enum logic [5:0] {
    FN_SLL  = 6'h00, FN_SRL   = 6'h02, FN_SRA  = 6'h03, FN_SLLV  = 6'h04,
    FN_SRLV = 6'h06, FN_SRAV  = 6'h07, FN_JR   = 6'h08, FN_JALR  = 6'h09,
    FN_MFHI = 6'h10, FN_MTHI  = 6'h11, FN_MFLO = 6'h12, FN_MTLO  = 6'h13,
    FN_MULT = 6'h18, FN_MULTU = 6'h19, FN_DIV  = 6'h1A, FN_DIVU  = 6'h1B,
    FN_ADD  = 6'h20, FN_ADDU  = 6'h21, FN_SUB  = 6'h22, FN_SUBU  = 6'h23,
    FN_AND  = 6'h24, FN_OR    = 6'h25, FN_XOR  = 6'h26, FN_NOR   = 6'h27,
    FN_SLT  = 6'h2A, FN_SLTU  = 6'h2B
  } funct_t;

  // REGIMM branch condition, bits 20..16
  typedef enum logic [4:0] {
    CD_BLTZ = 5'h00, CD_BGEZ = 5'h01, CD_BLTZAL = 5'h10, CD_BGEZAL = 5'h11
  } cond_t;

  // Dense instruction kind
  typedef enum logic [5:0] {
    K_ADD    = 6'd0,  K_ADDU  = 6'd1,  K_SUB    = 6'd2,  K_SUBU   = 6'd3,
    K_AND    = 6'd4,  K_OR    = 6'd5,  K_NOR    = 6'd6,  K_XOR    = 6'd7,
    K_JR     = 6'd8,  K_JALR  = 6'd9,  K_MULT   = 6'd10, K_MULTU  = 6'd11,
    K_DIV    = 6'd12, K_DIVU  = 6'd13, K_MFHI   = 6'd14, K_MFLO   = 6'd15,
    K_MTHI   = 6'd16, K_MTLO  = 6'd17, K_SLT    = 6'd18, K_SLTU   = 6'd19,
    K_SLL    = 6'd20, K_SLLV  = 6'd21, K_SRA    = 6'd22, K_SRAV   = 6'd23,
    K_SRL    = 6'd24, K_SRLV  = 6'd25, K_ADDI   = 6'd26, K_ADDIU  = 6'd27,
    K_ANDI   = 6'd28, K_ORI   = 6'd29, K_XORI   = 6'd30, K_SLTI   = 6'd31,
    K_SLTIU  = 6'd32, K_LUI   = 6'd33, K_LW     = 6'd34, K_LB     = 6'd35,
    K_LBU    = 6'd36, K_LH    = 6'd37, K_LHU    = 6'd38, K_SW     = 6'd39,
    K_SB     = 6'd40, K_SH    = 6'd41, K_BEQ    = 6'd42, K_BGTZ   = 6'd43,
    K_BLEZ   = 6'd44, K_BNE   = 6'd45, K_LWL    = 6'd46, K_BGEZ   = 6'd47,
    K_BGEZAL = 6'd48, K_BLTZ  = 6'd49, K_BLTZAL = 6'd50, K_J      = 6'd51,
    K_JAL    = 6'd52
  } kind_t;

  // Error code
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FUNCT  = 2'd1,
    ERR_OPCODE = 2'd2,
    ERR_COND   = 2'd3
  } err_t;

  typedef struct packed {
    kind_t kind;
    err_t  error;
  } dec_t;

  // Map one instruction word to its kind and error code
  function automatic dec_t decode_word(logic [31:0] word);
    dec_t       d;
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] cd;
    op = word[31:26];
    fn = word[5:0];
    cd = word[20:16];
    d.kind  = K_ADD;
    d.error = ERR_NONE;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_ADD:   d.kind = K_ADD;
          FN_ADDU:  d.kind = K_ADDU;
          FN_SUB:   d.kind = K_SUB;
          FN_SUBU:  d.kind = K_SUBU;
          FN_AND:   d.kind = K_AND;
          FN_OR:    d.kind = K_OR;
          FN_NOR:   d.kind = K_NOR;
          FN_XOR:   d.kind = K_XOR;
          FN_JR:    d.kind = K_JR;
          FN_JALR:  d.kind = K_JALR;
          FN_MULT:  d.kind = K_MULT;
          FN_MULTU: d.kind = K_MULTU;
          FN_DIV:   d.kind = K_DIV;
          FN_DIVU:  d.kind = K_DIVU;
          FN_MFHI:  d.kind = K_MFHI;
          FN_MFLO:  d.kind = K_MFLO;
          FN_MTHI:  d.kind = K_MTHI;
          FN_MTLO:  d.kind = K_MTLO;
          FN_SLT:   d.kind = K_SLT;
          FN_SLTU:  d.kind = K_SLTU;
          FN_SLL:   d.kind = K_SLL;
          FN_SLLV:  d.kind = K_SLLV;
          FN_SRA:   d.kind = K_SRA;
          FN_SRAV:  d.kind = K_SRAV;
          FN_SRL:   d.kind = K_SRL;
          FN_SRLV:  d.kind = K_SRLV;
          default:  d.error = ERR_FUNCT;
        endcase
      end
      OP_REGIMM: begin
        unique case (cd)
          CD_BGEZ:   d.kind = K_BGEZ;
          CD_BGEZAL: d.kind = K_BGEZAL;
          CD_BLTZ:   d.kind = K_BLTZ;
          CD_BLTZAL: d.kind = K_BLTZAL;
          default:   d.error = ERR_COND;
        endcase
      end
      OP_J:     d.kind = K_J;
      OP_JAL:   d.kind = K_JAL;
      OP_ADDI:  d.kind = K_ADDI;
      OP_ADDIU: d.kind = K_ADDIU;
      OP_ANDI:  d.kind = K_ANDI;
      OP_ORI:   d.kind = K_ORI;
      OP_XORI:  d.kind = K_XORI;
      OP_SLTI:  d.kind = K_SLTI;
      OP_SLTIU: d.kind = K_SLTIU;
      OP_LUI:   d.kind = K_LUI;
      OP_LW:    d.kind = K_LW;
      OP_LB:    d.kind = K_LB;
      OP_LBU:   d.kind = K_LBU;
      OP_LH:    d.kind = K_LH;
      OP_LHU:   d.kind = K_LHU;
      OP_SW:    d.kind = K_SW;
      OP_SB:    d.kind = K_SB;
      OP_SH:    d.kind = K_SH;
      OP_BEQ:   d.kind = K_BEQ;
      OP_BGTZ:  d.kind = K_BGTZ;
      OP_BLEZ:  d.kind = K_BLEZ;
      OP_BNE:   d.kind = K_BNE;
      OP_LWL:   d.kind = K_LWL;
      default:  d.error = ERR_OPCODE;
    endcase
    return d;
  endfunction

endpackage

@@ design/instruction_word_decoder.sv @@
// ----------------------------------------------------------------------------
// Instruction word decoder
// Decodes a 32-bit instruction word into a kind number, an error code and
// the raw register, shift, immediate and jump target fields.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in_      | input     | in_valid/in_ready   | in_instr_word
//  out_     | output    | out_valid/out_ready | kind, error, reg fields,
//           |           |                     | immediate, jump_target
//
// One word is taken per cycle while out_ready holds; a word passes the input
// register, the decode logic and the result register before it is offered.
// Sustained rate is one word per cycle while out_ready holds, set by the
// single decode stage.
// rst_n (synchronous) empties both stages; payload registers are not reset.
// A stalled result holds in the result register while the input register
// can still take one more word.
`include "instruction_word_decoder_defines.svh"

module instruction_word_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_kind,
  output logic [1:0]  out_error,
  output logic [4:0]  out_src_reg,
  output logic [4:0]  out_tgt_reg,
  output logic [4:0]  out_dst_reg,
  output logic [4:0]  out_shift_amount,
  output logic [15:0] out_immediate,
  output logic [25:0] out_jump_target
);
  import iwd_pkg::*;

  logic        in_valid_r;
  logic [31:0] word_r;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  dec_t        dec_r;
  dec_t        dec_nxt;
  logic        res_load;
  logic        in_take;
  logic [5:0]  out_op;
  logic        chk_err;
  logic        chk_fn_err;
  logic        chk_cd_err;

  // Load the result stage when it is empty or its transfer completes
  assign res_load = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || res_load;
  assign in_take  = in_valid && in_ready;

  // Decode the registered word
  assign dec_nxt = decode_word(word_r);

  // Advance stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (res_load) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Hold payloads until the next stage frees
  always_ff @(posedge clk) begin
    if (in_take) begin
      word_r <= in_instr_word;
    end
    if (res_load && in_valid_r) begin
      out_word_r <= word_r;
      dec_r      <= dec_nxt;
    end
  end

  // Drive result fields
  assign out_valid        = out_valid_r;
  assign out_kind         = dec_r.kind;
  assign out_error        = dec_r.error;
  assign out_src_reg      = out_word_r[25:21];
  assign out_tgt_reg      = out_word_r[20:16];
  assign out_dst_reg      = out_word_r[15:11];
  assign out_shift_amount = out_word_r[10:6];
  assign out_immediate    = out_word_r[15:0];
  assign out_jump_target  = out_word_r[25:0];

  // Check terms on the held result
  assign out_op     = out_word_r[31:26];
  assign chk_err    = out_valid_r && (dec_r.error != ERR_NONE);
  assign chk_fn_err = out_valid_r && (dec_r.error == ERR_FUNCT);
  assign chk_cd_err = out_valid_r && (dec_r.error == ERR_COND);

  // Checks
  `IWD_ASSERT_SAME(a_err_kind_zero, clk, rst_n, chk_err, dec_r.kind == K_ADD)
  `IWD_ASSERT_SAME(a_funct_err_special, clk, rst_n, chk_fn_err, out_op == OP_SPECIAL)
  `IWD_ASSERT_SAME(a_cond_err_regimm, clk, rst_n, chk_cd_err, out_op == OP_REGIMM)
  `IWD_ASSERT_NEXT(a_stage_moves, clk, rst_n, in_valid_r && res_load, out_valid_r)

endmodule
